/* src/float32_multiplier_truncating_top_assert.svh */
// ----------------------------------------------------------------------------
// float32_multiplier_truncating_top_assert
// Assertion macros for the truncating multiplier.
// ----------------------------------------------------------------------------
`ifndef FLOAT32_MULTIPLIER_TRUNCATING_TOP_ASSERT_SVH
`define FLOAT32_MULTIPLIER_TRUNCATING_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define FMT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent, delayed by the macro argument n.
`define FMT_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

/* src/fmt_pkg.sv */
// ----------------------------------------------------------------------------
// fmt_pkg
// Shared constants and stage payload types for the truncating multiplier.
// ----------------------------------------------------------------------------
package fmt_pkg;

  localparam int unsigned Latency = 3;
  localparam logic [7:0] ExpMax  = 8'hFF;
  localparam logic [9:0] ExpBias = 10'd127;

  // decoded operands, stage 1 to stage 2
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        inf;
    logic [9:0]  exp_sum;
    logic [23:0] man_a;
    logic [23:0] man_b;
  } fmt_dec_t;

  // raw product, stage 2 to stage 3
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        inf;
    logic [9:0]  exp_sum;
    logic [47:0] prod;
  } fmt_mul_t;

endpackage

/* src/fmt_decode.sv */
// ----------------------------------------------------------------------------
// fmt_decode
// Operand unpacking, special-case detection and exponent sum.
// ----------------------------------------------------------------------------
module fmt_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [31:0]      operand_a_i,
  input  logic [31:0]      operand_b_i,
  output logic             valid_o,
  output fmt_pkg::fmt_dec_t dec_o
);
  logic              valid_q;
  fmt_pkg::fmt_dec_t dec_d, dec_q;

  always_comb begin
    dec_d.sign    = operand_a_i[31] ^ operand_b_i[31];
    dec_d.zero    = (operand_a_i[30:23] == 8'd0) || (operand_b_i[30:23] == 8'd0);
    dec_d.inf     = (operand_a_i[30:23] == fmt_pkg::ExpMax) ||
                    (operand_b_i[30:23] == fmt_pkg::ExpMax);
    dec_d.exp_sum = {2'b00, operand_a_i[30:23]} + {2'b00, operand_b_i[30:23]};
    dec_d.man_a   = {1'b1, operand_a_i[22:0]};
    dec_d.man_b   = {1'b1, operand_b_i[22:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) dec_q <= dec_d;
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;
endmodule

/* src/fmt_mult.sv */
// ----------------------------------------------------------------------------
// fmt_mult
// 24x24 significand multiply stage.
// ----------------------------------------------------------------------------
module fmt_mult (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fmt_pkg::fmt_dec_t dec_i,
  output logic              valid_o,
  output fmt_pkg::fmt_mul_t mul_o
);
  logic              valid_q;
  fmt_pkg::fmt_mul_t mul_d, mul_q;

  always_comb begin
    mul_d.sign    = dec_i.sign;
    mul_d.zero    = dec_i.zero;
    mul_d.inf     = dec_i.inf;
    mul_d.exp_sum = dec_i.exp_sum;
    mul_d.prod    = {24'd0, dec_i.man_a} * {24'd0, dec_i.man_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) mul_q <= mul_d;
  end

  assign valid_o = valid_q;
  assign mul_o   = mul_q;
endmodule

/* src/fmt_pack.sv */
// ----------------------------------------------------------------------------
// fmt_pack
// Normalize by one bit, truncate, range check and result packing.
// ----------------------------------------------------------------------------
module fmt_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fmt_pkg::fmt_mul_t mul_i,
  output logic              valid_o,
  output logic [31:0]       product_o,
  output logic              overflowed_o,
  output logic              underflowed_o
);
  logic        valid_q;
  logic        bump;
  logic [9:0]  exp_r;
  logic [22:0] frac;
  logic [31:0] prod_d, prod_q;
  logic        ovf_d, ovf_q, unf_d, unf_q;

  always_comb begin
    bump  = mul_i.prod[47];
    frac  = bump ? mul_i.prod[46:24] : mul_i.prod[45:23];
    // for non-special operands exp_sum in 2..508; result in -125..382, 10-bit two's complement
    exp_r = mul_i.exp_sum - fmt_pkg::ExpBias + {9'd0, bump};
    ovf_d = 1'b0;
    unf_d = 1'b0;
    if (mul_i.zero) begin
      prod_d = {mul_i.sign, 31'd0};
    end else if (mul_i.inf) begin
      prod_d = {mul_i.sign, fmt_pkg::ExpMax, 23'd0};
    end else if (!exp_r[9] && exp_r[8:0] >= {1'b0, fmt_pkg::ExpMax}) begin
      prod_d = {mul_i.sign, fmt_pkg::ExpMax, 23'd0};
      ovf_d  = 1'b1;
    end else if (exp_r[9] || exp_r == 10'd0) begin
      prod_d = {mul_i.sign, 31'd0};
      unf_d  = 1'b1;
    end else begin
      prod_d = {mul_i.sign, exp_r[7:0], frac};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= prod_d;
      ovf_q  <= ovf_d;
      unf_q  <= unf_d;
    end
  end

  assign valid_o       = valid_q;
  assign product_o     = prod_q;
  assign overflowed_o  = ovf_q;
  assign underflowed_o = unf_q;
endmodule

/* src/float32_multiplier_truncating_top.sv */
// ----------------------------------------------------------------------------
// float32_multiplier_truncating_top
// Truncating IEEE-754 single-precision multiplier, three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operand_a_i / operand_b_i and raise start_i; an item is taken at
//   each edge where start_i is high and busy_o is low. busy_o is always low:
//   one item per cycle, back to back.
//   The path runs through decode, 24x24 multiply, normalize and pack, each
//   a register stage. The result shows on product_o, overflowed_o and
//   underflowed_o for one cycle with done_o high.
//   Throughput is one item per cycle, as no stage can stall.
//   Reset clears the stage valid bits; no results appear until items enter.
//   The receiver cannot stall; results are taken in the cycle they appear.
// ----------------------------------------------------------------------------
`include "float32_multiplier_truncating_top_assert.svh"

module float32_multiplier_truncating_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] product_o,
  output logic        overflowed_o,
  output logic        underflowed_o
);
  logic              accept;
  logic              dec_valid, mul_valid;
  fmt_pkg::fmt_dec_t dec;
  fmt_pkg::fmt_mul_t mul;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  fmt_decode u_decode (
    .clk_i, .rst_ni, .valid_i(accept), .operand_a_i, .operand_b_i,
    .valid_o(dec_valid), .dec_o(dec)
  );

  fmt_mult u_mult (
    .clk_i, .rst_ni, .valid_i(dec_valid), .dec_i(dec),
    .valid_o(mul_valid), .mul_o(mul)
  );

  fmt_pack u_pack (
    .clk_i, .rst_ni, .valid_i(mul_valid), .mul_i(mul),
    .valid_o(done_o), .product_o, .overflowed_o, .underflowed_o
  );

  `FMT_ASSERT_DELAY(a_latency, clk_i, rst_ni, accept, fmt_pkg::Latency, done_o, "item lost in pipeline")
  `FMT_ASSERT_IMPL(a_flags_excl, clk_i, rst_ni, done_o, !(overflowed_o && underflowed_o), "both flags set")
  `FMT_ASSERT_IMPL(a_ovf_inf, clk_i, rst_ni, done_o && overflowed_o, product_o[30:0] == 31'h7F800000, "overflow not infinity")
  `FMT_ASSERT_IMPL(a_unf_zero, clk_i, rst_ni, done_o && underflowed_o, product_o[30:0] == 31'd0, "underflow not zero")
endmodule

/* bench/float32_multiplier_truncating_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_multiplier_truncating_top_tb
// Self-checking bench for the truncating single-precision multiplier: a
// directed table of corner operands, then random items, each product checked
// against the table or a behavioral predictor via a queue of expected results.
// ----------------------------------------------------------------------------
module float32_multiplier_truncating_top_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef struct {
    logic [31:0] product;
    logic        overflowed;
    logic        underflowed;
  } fmul_result_t;

  typedef struct {
    logic [31:0]  a;
    logic [31:0]  b;
    bit           typed;
    fmul_result_t res;
  } fmul_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        done_o;
  logic [31:0] product_o;
  logic        overflowed_o;
  logic        underflowed_o;

  fmul_result_t pending_products[$];
  int unsigned  fail_count;
  int unsigned  checked_count;
  int unsigned  ovf_seen;
  int unsigned  unf_seen;
  int unsigned  cycle_count;
  int unsigned  idle_pct;

  float32_multiplier_truncating_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .done_o       (done_o),
    .product_o    (product_o),
    .overflowed_o (overflowed_o),
    .underflowed_o(underflowed_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic fmul_result_t predict_product(logic [31:0] a, logic [31:0] b);
    fmul_result_t r;
    logic         sgn;
    logic [7:0]   ea;
    logic [7:0]   eb;
    logic [47:0]  mant;
    logic         bump;
    int           ex;
    sgn = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    r.overflowed = 1'b0;
    r.underflowed = 1'b0;
    if (ea == 8'd0 || eb == 8'd0) begin
      r.product = {sgn, 31'd0};
    end else if (ea == fmt_pkg::ExpMax || eb == fmt_pkg::ExpMax) begin
      r.product = {sgn, fmt_pkg::ExpMax, 23'd0};
    end else begin
      mant = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
      bump = mant[47];
      ex = int'(ea) + int'(eb) - int'(fmt_pkg::ExpBias) + (bump ? 1 : 0);
      if (ex >= int'(fmt_pkg::ExpMax)) begin
        r.product = {sgn, fmt_pkg::ExpMax, 23'd0};
        r.overflowed = 1'b1;
      end else if (ex <= 0) begin
        r.product = {sgn, 31'd0};
        r.underflowed = 1'b1;
      end else begin
        r.product = {sgn, ex[7:0], bump ? mant[46:24] : mant[45:23]};
      end
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    fmul_result_t want;
    if (rst_ni && done_o) begin
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected result product=%h ovf=%b unf=%b", $time,
                 product_o, overflowed_o, underflowed_o);
        fail_count++;
      end else begin
        want = pending_products.pop_front();
        checked_count++;
        if (overflowed_o) ovf_seen++;
        if (underflowed_o) unf_seen++;
        if (product_o !== want.product || overflowed_o !== want.overflowed ||
            underflowed_o !== want.underflowed) begin
          $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                   want.product, want.overflowed, want.underflowed,
                   product_o, overflowed_o, underflowed_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one item at the next accepting edge, with a random gap before it when idle_pct is nonzero
  task automatic send_item(logic [31:0] a, logic [31:0] b, fmul_result_t res);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_products.push_back(res);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'd1 + 8'($urandom_range(20));
      3: v[30:23] = 8'd234 + 8'($urandom_range(20));
      default: v[30:23] = 8'd64 + 8'($urandom_range(127));
    endcase
    return v;
  endfunction

  initial begin
    fmul_row_t    dir_rows[$];
    fmul_result_t exp_res;
    logic [31:0]  a;
    logic [31:0]  b;
    fail_count = 0;
    checked_count = 0;
    ovf_seen = 0;
    unf_seen = 0;
    cycle_count = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    operand_a_i = '0;
    operand_b_i = '0;

    dir_rows = '{
      '{32'h3F800000, 32'h3F800000, 1'b1, '{32'h3F800000, 1'b0, 1'b0}},
      '{32'h00000000, 32'h3F800000, 1'b1, '{32'h00000000, 1'b0, 1'b0}},
      '{32'h80000000, 32'h3F800000, 1'b1, '{32'h80000000, 1'b0, 1'b0}},
      '{32'h007FFFFF, 32'hBF800000, 1'b1, '{32'h80000000, 1'b0, 1'b0}},
      '{32'h00000000, 32'h7F800000, 1'b1, '{32'h00000000, 1'b0, 1'b0}},
      '{32'h7F800000, 32'hBF800000, 1'b1, '{32'hFF800000, 1'b0, 1'b0}},
      '{32'h7FC00000, 32'h3F800000, 1'b1, '{32'h7F800000, 1'b0, 1'b0}},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'h7F800000, 1'b0, 1'b0}},
      '{32'h7F7FFFFF, 32'h7F7FFFFF, 1'b1, '{32'h7F800000, 1'b1, 1'b0}},
      '{32'hFF7FFFFF, 32'h40000000, 1'b1, '{32'hFF800000, 1'b1, 1'b0}},
      '{32'h00800000, 32'h00800000, 1'b1, '{32'h00000000, 1'b0, 1'b1}},
      '{32'h80800000, 32'h3F000000, 1'b1, '{32'h80000000, 1'b0, 1'b1}},
      '{32'h3FFFFFFF, 32'h3FFFFFFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{32'h40400000, 32'hC0A00000, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{32'h00FFFFFF, 32'h3F800000, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{32'h7F000000, 32'h3FFFFFFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{32'h5A5A5A5A, 32'hA5A5A5A5, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{32'h20000000, 32'h1F800001, 1'b0, '{32'h0, 1'b0, 1'b0}}
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      exp_res = dir_rows[i].typed ? dir_rows[i].res
                                  : predict_product(dir_rows[i].a, dir_rows[i].b);
      send_item(dir_rows[i].a, dir_rows[i].b, exp_res);
    end

    // hold off until the pipeline has emptied
    start_i <= 1'b0;
    while (pending_products.size() != 0) @(negedge clk_i);

    for (int i = 0; i < 1000; i++) begin
      idle_pct = (i < 333) ? 21 : (i < 666) ? 59 : 0;
      a = random_operand();
      b = random_operand();
      send_item(a, b, predict_product(a, b));
    end
    start_i <= 1'b0;

    while (pending_products.size() != 0 && cycle_count < CycleLimit) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Checked %0d products: %0d saturated, %0d flushed to zero.",
             checked_count, ovf_seen, unf_seen);
    $display("Directed corners plus random operands across three idle profiles.");
    if (fail_count == 0 && pending_products.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
